@@ sv/bpfe_pkg.sv @@
`default_nettype none
package bpfe_pkg;
  typedef enum logic [2:0] {
    ACT_ISSUE = 3'd0,
    ACT_OTHER_FORK = 3'd1,
    ACT_FULL_IMAGE = 3'd2,
    ACT_WILL_INIT = 3'd3,
    ACT_FILTERED = 3'd4,
    ACT_REPEAT = 3'd5,
    ACT_DONE = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    OP_BLOCK_REF = 2'd0,
    OP_REPLAY = 2'd1,
    OP_CREATE = 2'd2,
    OP_MISSING = 2'd3
  } op_t;
endpackage
`default_nettype wire

@@ sv/block_prefetch_filter_engine.sv @@
// Prefetch filter engine for block references read ahead in a write-ahead log.
// A request enters on the input channel (in_valid, in_stall) and one result
// leaves on the output channel (out_valid, out_stall) with fields action and
// table_full. The engine handles one request at a time and raises in_stall
// while busy. Each request walks the filter table one slot per cycle through
// a single shared compare unit, then passes to a write state and on to an
// output state that holds the result. When a filter must be stored, the
// first free slot and the first slot with a matching key are both found
// during the same walk, and the update is written in the write state. A
// stalled result holds; the engine takes no new request until it is
// delivered. Synchronous reset clears all valid bits, the last issued key
// and block, the replay position and the full-page setting; there is no
// clearing pass. The setting prefetch_full_pages must be written through
// cfg_we and cfg_data only while the engine is idle; the engine itself
// does not enforce this.
`default_nettype none
module block_prefetch_filter_engine #(
  parameter int FILTER_SLOTS = 64
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic cfg_data,
  input wire logic in_valid,
  output logic in_stall,
  input wire logic [1:0] op,
  input wire logic [31:0] space_id,
  input wire logic [31:0] database_id,
  input wire logic [31:0] relation_id,
  input wire logic [31:0] block_no,
  input wire logic [63:0] record_lsn,
  input wire logic main_fork,
  input wire logic page_image,
  input wire logic will_init,
  output logic out_valid,
  input wire logic out_stall,
  output logic [2:0] action,
  output logic table_full
);
  localparam int IW = $clog2(FILTER_SLOTS);
  localparam int CW = $clog2(FILTER_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SCAN, S_WRITE, S_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] sp;
    logic [31:0] db;
    logic [31:0] rel;
    logic [31:0] first;
    logic [63:0] pos;
  } slot_t;

  slot_t mem [FILTER_SLOTS];
  slot_t rd;
  logic [FILTER_SLOTS-1:0] valid;

  state_t state;
  logic prefetch_full_pages;
  logic [1:0] r_op;
  logic [31:0] r_sp, r_db, r_rel, r_blk;
  logic [63:0] r_lsn;
  logic r_main, r_img, r_init;
  logic [31:0] prev_space, prev_database, prev_relation, prev_block;
  logic [63:0] replay_position;
  logic [CW-1:0] cnt;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] scan_idx;
  logic hit_found, free_found;
  logic [IW-1:0] hit_idx, free_idx;
  logic [31:0] hit_first;
  logic add_req;
  logic [31:0] add_blk;
  logic key_eq;

  assign in_stall = (state != S_IDLE);
  assign key_eq = rd.sp == r_sp && rd.db == r_db && rd.rel == r_rel;
  assign rd_idx = (state == S_IDLE) ? '0 : cnt[IW-1:0];

  always_ff @(posedge clk) begin
    rd <= mem[rd_idx];
    if (state == S_WRITE && add_req) begin
      if (hit_found) begin
        mem[hit_idx].pos <= r_lsn;
        if (add_blk < hit_first) begin
          mem[hit_idx].first <= add_blk;
        end
      end else if (free_found) begin
        mem[free_idx] <= '{r_sp, r_db, r_rel, add_blk, r_lsn};
      end
    end
  end

  always_comb begin
    add_req = 1'b0;
    add_blk = r_blk;
    case (r_op)
      bpfe_pkg::OP_BLOCK_REF: add_req = r_main && !(r_img && !prefetch_full_pages) && r_init;
      bpfe_pkg::OP_CREATE: begin
        add_req = replay_position < r_lsn;
        add_blk = '0;
      end
      bpfe_pkg::OP_MISSING: begin
        add_req = 1'b1;
        add_blk = '0;
      end
      default: add_req = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      prefetch_full_pages <= 1'b0;
      prev_space <= '0;
      prev_database <= '0;
      prev_relation <= '0;
      prev_block <= '0;
      replay_position <= '0;
      out_valid <= 1'b0;
      cnt <= '0;
    end else begin
      if (cfg_we) begin
        prefetch_full_pages <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_op <= op;
            r_sp <= space_id;
            r_db <= database_id;
            r_rel <= relation_id;
            r_blk <= block_no;
            r_lsn <= record_lsn;
            r_main <= main_fork;
            r_img <= page_image;
            r_init <= will_init;
            hit_found <= 1'b0;
            free_found <= 1'b0;
            cnt <= CW'(1);
            scan_idx <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (valid[scan_idx]) begin
            if (r_op == bpfe_pkg::OP_REPLAY) begin
              if (rd.pos < r_lsn) begin
                valid[scan_idx] <= 1'b0;
              end
            end else if (key_eq && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx <= scan_idx;
              hit_first <= rd.first;
            end
          end else if (!free_found) begin
            free_found <= 1'b1;
            free_idx <= scan_idx;
          end
          scan_idx <= scan_idx + IW'(1);
          cnt <= cnt + CW'(1);
          if (scan_idx == IW'(FILTER_SLOTS - 1)) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          table_full <= 1'b0;
          action <= bpfe_pkg::ACT_DONE;
          if (add_req && !hit_found) begin
            if (free_found) begin
              valid[free_idx] <= 1'b1;
            end else begin
              table_full <= 1'b1;
            end
          end
          case (r_op)
            bpfe_pkg::OP_BLOCK_REF: begin
              if (!r_main) begin
                action <= bpfe_pkg::ACT_OTHER_FORK;
              end else if (r_img && !prefetch_full_pages) begin
                action <= bpfe_pkg::ACT_FULL_IMAGE;
              end else if (r_init) begin
                action <= bpfe_pkg::ACT_WILL_INIT;
              end else if (hit_found && hit_first <= r_blk) begin
                action <= bpfe_pkg::ACT_FILTERED;
              end else if (r_sp == prev_space && r_db == prev_database &&
                           r_rel == prev_relation && r_blk == prev_block) begin
                action <= bpfe_pkg::ACT_REPEAT;
              end else begin
                prev_space <= r_sp;
                prev_database <= r_db;
                prev_relation <= r_rel;
                prev_block <= r_blk;
                action <= bpfe_pkg::ACT_ISSUE;
              end
            end
            bpfe_pkg::OP_REPLAY: replay_position <= r_lsn;
            default: ;
          endcase
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_OUT)
    else $error("result valid outside output state");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("result repeated");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !table_full |-> action <= bpfe_pkg::ACT_DONE)
    else $error("bad action");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> action == bpfe_pkg::ACT_WILL_INIT ||
      action == bpfe_pkg::ACT_DONE)
    else $error("table full on wrong action");
endmodule
`default_nettype wire
